### sv/caldc_pkg.sv
// Shared types, constants and calendar helper functions for the date completion core.
`default_nettype none

package caldc_pkg;

	localparam int unsigned YearW  = 14;
	localparam int unsigned MonthW = 4;
	localparam int unsigned MdayW  = 5;
	localparam int unsigned YdayW  = 9;
	localparam int unsigned WdayW  = 3;
	localparam int unsigned WsW    = 2;
	localparam int unsigned WeekW  = 6;
	localparam int unsigned KnownW = 5;

	localparam logic [MonthW-1:0] LastMonth  = 4'd11;
	localparam logic [WsW-1:0]    WsNone     = 2'd0;
	localparam logic [WsW-1:0]    WsSunday   = 2'd1;
	localparam logic [WsW-1:0]    WsMonday   = 2'd2;
	localparam logic [YdayW-1:0]  DaysCommon = 9'd365;

	localparam int unsigned KYear  = 0;
	localparam int unsigned KMonth = 1;
	localparam int unsigned KMday  = 2;
	localparam int unsigned KYday  = 3;
	localparam int unsigned KWday  = 4;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic              year_known;
		logic [MonthW-1:0] month;
		logic              month_known;
		logic [MdayW-1:0]  mday;
		logic              mday_known;
		logic [YdayW-1:0]  yday;
		logic              yday_known;
		logic [WdayW-1:0]  wday;
		logic              wday_known;
		logic [WsW-1:0]    week_start;
		logic [WeekW-1:0]  week_number;
	} item_t;

	// Calendar facts for the given year and for the year after it.
	typedef struct packed {
		logic             leap0;
		logic             leap1;
		logic [WdayW-1:0] jan0;
		logic [WdayW-1:0] jan1;
	} year_info_t;

	typedef struct packed {
		logic [YearW:0]     year;
		logic [MonthW-1:0]  month;
		logic [MdayW-1:0]   mday;
		logic [YdayW-1:0]   yday;
		logic [WdayW-1:0]   wday;
		logic [KnownW-1:0]  known;
		logic               err;
	} date_t;

	// First day of year of a month; index twelve is the length of the year.
	function automatic logic [YdayW-1:0] month_start(input logic leap,
			input logic [MonthW-1:0] idx);
		logic [YdayW-1:0] base;
		logic             extra;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			4'd12:   base = 9'd365;
			default: base = 9'd0;
		endcase
		extra = leap && (idx >= 4'd2) && (idx <= 4'd12);
		return base + {8'd0, extra};
	endfunction

	// Remainder by seven through a reciprocal multiply, exact for inputs below 685.
	function automatic logic [WdayW-1:0] mod7(input logic [9:0] x);
		logic [18:0] p;
		logic [7:0]  q;
		logic [10:0] q7;
		logic [10:0] r;
		p  = 19'(x) * 19'(293);
		q  = p[18:11];
		q7 = {q, 3'b000} - {3'b000, q};
		r  = {1'b0, x} - q7;
		return r[WdayW-1:0];
	endfunction

endpackage

`default_nettype wire

### sv/caldc_year_info.sv
// Two pipeline stages that find leap flags and January first weekdays of a year and its successor.
`default_nettype none

module caldc_year_info (
	input  wire logic                   clk,
	input  wire logic                   en_s1,
	input  wire logic                   en_s2,
	input  wire caldc_pkg::item_t       item,
	output caldc_pkg::item_t            item_s2,
	output caldc_pkg::year_info_t       info_s2
);

	caldc_pkg::item_t item_s1;
	logic [7:0]       q0_s1;
	logic [7:0]       q1_s1;
	logic [14:0]      y1_s1;

	logic [14:0] y1;
	logic [27:0] p0;
	logic [27:0] p1;

	function automatic logic leap_of(input logic [1:0] ylow, input logic [6:0] r,
			input logic [1:0] c);
		return ((ylow == 2'd0) && (r != 7'd0)) || ((r == 7'd0) && (c == 2'd0));
	endfunction

	function automatic logic [2:0] jan1_of(input logic [6:0] r, input logic [1:0] c,
			input logic leap);
		logic [9:0] s;
		s = {6'd0, 3'd3 - {1'b0, c}, 1'b0} + {3'd0, r} + {5'd0, r[6:2]}
			+ (leap ? 10'd6 : 10'd0) + 10'd1;
		return caldc_pkg::mod7(s);
	endfunction

	assign y1 = {1'b0, item.year} + 15'd1;
	assign p0 = 28'(item.year) * 28'(5243);
	assign p1 = 28'(y1) * 28'(5243);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= item;
			q0_s1   <= p0[26:19];
			q1_s1   <= p1[26:19];
			y1_s1   <= y1;
		end
	end

	logic [14:0] r0;
	logic [14:0] r1;
	logic        leap0;
	logic        leap1;

	always_comb begin
		r0    = {1'b0, item_s1.year} - 15'(q0_s1) * 15'(100);
		r1    = y1_s1 - 15'(q1_s1) * 15'(100);
		leap0 = leap_of(item_s1.year[1:0], r0[6:0], q0_s1[1:0]);
		leap1 = leap_of(y1_s1[1:0], r1[6:0], q1_s1[1:0]);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2       <= item_s1;
			info_s2.leap0 <= leap0;
			info_s2.leap1 <= leap1;
			info_s2.jan0  <= jan1_of(r0[6:0], q0_s1[1:0], leap0);
			info_s2.jan1  <= jan1_of(r1[6:0], q1_s1[1:0], leap1);
		end
	end

endmodule

`default_nettype wire

### sv/caldc_yday_derive.sv
// Pipeline stage that derives the day of year from month and day or from week position.
`default_nettype none

module caldc_yday_derive (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire caldc_pkg::item_t       item,
	input  wire caldc_pkg::year_info_t  info,
	output caldc_pkg::date_t            date_s3,
	output caldc_pkg::year_info_t       info_s3
);

	caldc_pkg::date_t d;
	logic [9:0]       e;
	logic [8:0]       next_start;
	logic             ds;
	logic [3:0]       ta;
	logic [2:0]       a;
	logic [2:0]       b;
	logic [10:0]      s;

	always_comb begin
		d.year   = {1'b0, item.year};
		d.month  = item.month;
		d.mday   = item.mday;
		d.yday   = item.yday;
		d.wday   = item.wday;
		d.known  = {item.wday_known, item.yday_known, item.mday_known,
			item.month_known, item.year_known};
		d.err    = 1'b0;
		e          = 10'(caldc_pkg::month_start(info.leap0, item.month))
			+ 10'(item.mday) - 10'd1;
		next_start = caldc_pkg::month_start(info.leap0, 4'(item.month + 4'd1));
		ds = (item.week_start == caldc_pkg::WsMonday);
		ta = 4'd7 - {1'b0, info.jan0} + {3'd0, ds};
		a  = (ta >= 4'd7) ? 3'(ta - 4'd7) : ta[2:0];
		b  = 3'd0;
		s  = 11'd0;
		if (item.year_known && !item.yday_known) begin
			if (item.month_known && item.mday_known) begin
				if ((item.month > caldc_pkg::LastMonth) || (item.mday == 5'd0)
						|| (e >= {1'b0, next_start})) begin
					d.err = 1'b1;
				end else begin
					d.yday              = e[8:0];
					d.known[caldc_pkg::KYday] = 1'b1;
				end
			end else if ((item.week_start == caldc_pkg::WsSunday)
					|| (item.week_start == caldc_pkg::WsMonday)) begin
				if (!item.wday_known) begin
					d.wday                    = {2'b00, ds};
					d.known[caldc_pkg::KWday] = 1'b1;
				end
				b = caldc_pkg::mod7(10'(d.wday) + 10'd7 - 10'(ds));
				s = 11'(a) + 11'(item.week_number) * 11'd7 + 11'(b);
				if (s < 11'd7) begin
					d.err = 1'b1;
				end else begin
					d.yday                    = 9'(s - 11'd7);
					d.known[caldc_pkg::KYday] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			date_s3 <= d;
			info_s3 <= info;
		end
	end

endmodule

`default_nettype wire

### sv/caldc_month_derive.sv
// Pipeline stage that wraps the day of year into the next year and derives the month.
`default_nettype none

module caldc_month_derive (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire caldc_pkg::date_t       date,
	input  wire caldc_pkg::year_info_t  info,
	output caldc_pkg::date_t            date_s4,
	output logic                        leap_s4,
	output logic [2:0]                  jan_s4
);

	caldc_pkg::date_t d;
	logic             leap;
	logic [2:0]       jan;
	logic [8:0]       len0;
	logic [8:0]       len;
	logic [3:0]       cnt;

	always_comb begin
		d    = date;
		leap = info.leap0;
		jan  = info.jan0;
		len0 = caldc_pkg::DaysCommon + {8'd0, info.leap0};
		len  = len0;
		cnt  = 4'd0;
		if (!date.err && date.known[caldc_pkg::KYear] && date.known[caldc_pkg::KYday]
				&& !date.known[caldc_pkg::KMonth]) begin
			if (date.yday >= len0) begin
				d.yday = date.yday - len0;
				d.year = date.year + 15'd1;
				leap   = info.leap1;
				jan    = info.jan1;
				len    = caldc_pkg::DaysCommon + {8'd0, info.leap1};
			end
			if (d.yday >= len) begin
				d.err = 1'b1;
			end else begin
				for (int i = 1; i <= 11; i++) begin
					if (d.yday >= caldc_pkg::month_start(leap, 4'(i))) begin
						cnt = cnt + 4'd1;
					end
				end
				d.month                    = cnt;
				d.known[caldc_pkg::KMonth] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			date_s4 <= d;
			leap_s4 <= leap;
			jan_s4  <= jan;
		end
	end

endmodule

`default_nettype wire

### sv/caldc_finish.sv
// Output stage that derives day of month and weekday and applies the error result.
`default_nettype none

module caldc_finish (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire caldc_pkg::date_t       date,
	input  wire logic                   leap,
	input  wire logic [2:0]             jan,
	output caldc_pkg::date_t            date_s5
);

	caldc_pkg::date_t d;
	logic             active;
	logic [8:0]       start;
	logic [8:0]       next_start;

	always_comb begin
		d          = date;
		active     = !date.err && date.known[caldc_pkg::KYear]
			&& date.known[caldc_pkg::KYday];
		start      = caldc_pkg::month_start(leap, date.month);
		next_start = caldc_pkg::month_start(leap, 4'(date.month + 4'd1));
		if (active && !date.known[caldc_pkg::KMday]) begin
			if ((date.month > caldc_pkg::LastMonth) || (date.yday < start)
					|| (date.yday >= next_start)) begin
				d.err = 1'b1;
			end else begin
				d.mday                    = 5'(date.yday - start + 9'd1);
				d.known[caldc_pkg::KMday] = 1'b1;
			end
		end
		if (active && !d.err && !date.known[caldc_pkg::KWday]) begin
			d.wday                    = caldc_pkg::mod7(10'(jan) + 10'(date.yday));
			d.known[caldc_pkg::KWday] = 1'b1;
		end
		if (d.err) begin
			d.mday                    = 5'd0;
			d.yday                    = 9'd0;
			d.known[caldc_pkg::KMday] = 1'b0;
			d.known[caldc_pkg::KYday] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			date_s5 <= d;
		end
	end

endmodule

`default_nettype wire

### sv/calendar_date_completion_core.sv
// Top level of the date completion core: handshake control and the five-stage pipeline.
// Usage:
// The item channel (item_valid, item_ready) takes one partly known Gregorian date per
// transaction: each field with its known flag, plus an optional week number with a
// Sunday or Monday week start. The result channel (result_valid, result_ready) returns
// one completed date per transaction, with a known mask and a range error flag.
// The five register stages (divide by 100, leap and weekday of January first, day of
// year, year wrap and month, then day of month and weekday into the output register)
// load in that order, the first at the accepting edge; result_valid follows the fifth.
// Throughput is one transaction per cycle while result_ready is high.
// When the receiver stalls, the output stage holds its transaction and the stages
// behind it keep filling bubbles, so item_ready drops only once every stage is full.
// Reset clears all stage valid bits; no item is lost or repeated across a stall.
`default_nettype none

module calendar_date_completion_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [13:0] year,
	input  wire logic        year_known,
	input  wire logic [3:0]  month,
	input  wire logic        month_known,
	input  wire logic [4:0]  mday,
	input  wire logic        mday_known,
	input  wire logic [8:0]  yday,
	input  wire logic        yday_known,
	input  wire logic [2:0]  wday,
	input  wire logic        wday_known,
	input  wire logic [1:0]  week_start,
	input  wire logic [5:0]  week_number,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [13:0]      out_year,
	output logic [3:0]       out_month,
	output logic [4:0]       out_mday,
	output logic [8:0]       out_yday,
	output logic [2:0]       out_wday,
	output logic [4:0]       known_mask,
	output logic             range_error
);

	caldc_pkg::item_t      item;
	caldc_pkg::item_t      item_s2;
	caldc_pkg::year_info_t info_s2;
	caldc_pkg::year_info_t info_s3;
	caldc_pkg::date_t      date_s3;
	caldc_pkg::date_t      date_s4;
	caldc_pkg::date_t      date_s5;
	logic                  leap_s4;
	logic [2:0]            jan_s4;

	logic [5:1] valid_q;
	logic [5:1] adv;

	assign item = '{year: year, year_known: year_known, month: month,
		month_known: month_known, mday: mday, mday_known: mday_known, yday: yday,
		yday_known: yday_known, wday: wday, wday_known: wday_known,
		week_start: week_start, week_number: week_number};

	always_comb begin
		adv[5] = !valid_q[5] || result_ready;
		for (int k = 4; k >= 1; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign item_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) begin
				valid_q[1] <= item_valid;
			end
			for (int k = 2; k <= 5; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	caldc_year_info u_year_info (
		.clk     (clk),
		.en_s1   (adv[1]),
		.en_s2   (adv[2]),
		.item    (item),
		.item_s2 (item_s2),
		.info_s2 (info_s2)
	);

	caldc_yday_derive u_yday (
		.clk     (clk),
		.en      (adv[3]),
		.item    (item_s2),
		.info    (info_s2),
		.date_s3 (date_s3),
		.info_s3 (info_s3)
	);

	caldc_month_derive u_month (
		.clk     (clk),
		.en      (adv[4]),
		.date    (date_s3),
		.info    (info_s3),
		.date_s4 (date_s4),
		.leap_s4 (leap_s4),
		.jan_s4  (jan_s4)
	);

	caldc_finish u_finish (
		.clk     (clk),
		.en      (adv[5]),
		.date    (date_s4),
		.leap    (leap_s4),
		.jan     (jan_s4),
		.date_s5 (date_s5)
	);

	assign result_valid = valid_q[5];
	assign out_year     = date_s5.year[13:0];
	assign out_month    = date_s5.month;
	assign out_mday     = date_s5.mday;
	assign out_yday     = date_s5.yday;
	assign out_wday     = date_s5.wday;
	assign known_mask   = date_s5.known;
	assign range_error  = date_s5.err;

endmodule

`default_nettype wire
